// ===== src/fts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_pkg
// Shared types and constants for the transmit framer with preamble and
// MSB-first serializer.
// ----------------------------------------------------------------------------
package fts_pkg;

    // Default sizes of the frame and of the byte store.
    localparam int FRAME_BYTES_DEF = 120;
    localparam int STORE_BYTES_DEF = 2048;

    // Configuration register and burst counter widths.
    localparam int CFG_W   = 12;
    localparam int BURST_W = 12;
    localparam logic [CFG_W-1:0] PREAMBLE_RESET = 12'd240;

    // Byte sent during a preamble.
    localparam logic [7:0] SYNC_BYTE = 8'h77;

    // Free frame count reported on every result.
    localparam int FF_W = 5;
    localparam logic [FF_W-1:0] FF_MAX = 5'd31;

    // Depth of the queue between the front and the serializer.
    localparam int QUEUE_DEPTH = 4;

    // Item kinds.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result kinds.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BIT    = 1'b1;

    // Load status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LENGTH  = 2'd1,
        ST_NO_ROOM = 2'd2
    } t_status;

    // One queued result: a load status or a whole byte to serialize.
    typedef struct packed {
        logic            kind;
        t_status         status;
        logic [7:0]      data;
        logic [FF_W-1:0] free_frames;
    } t_entry;

endpackage

// ===== src/fts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_front
// Accepts load and tick items, keeps the byte store and its pointers, and
// hands one queue entry per result-producing item to the serializer.
// ----------------------------------------------------------------------------
module fts_front #(
    parameter int FRAME_BYTES = fts_pkg::FRAME_BYTES_DEF,
    parameter int STORE_BYTES = fts_pkg::STORE_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [fts_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic                     i_mode,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_frame_end,
    input  logic                     i_tx_on,
    input  logic                     i_q_full,
    output logic                     o_q_push,
    output fts_pkg::t_entry          o_q_data
);

    localparam int PTR_W  = $clog2(STORE_BYTES);
    localparam int ROOM_W = $clog2(STORE_BYTES + 1);
    localparam int CNT_W  = $clog2(FRAME_BYTES + 3);
    localparam int REM_W  = $clog2(FRAME_BYTES + 1);
    localparam int CMP_W  = (ROOM_W > CNT_W) ? ROOM_W : CNT_W;
    localparam int Q_RESET = STORE_BYTES / FRAME_BYTES;
    localparam int R_RESET = STORE_BYTES % FRAME_BYTES;

    // Next position in the circular store.
    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(STORE_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [7:0] mem [STORE_BYTES];

    logic [fts_pkg::CFG_W-1:0]   r_preamble;
    logic [PTR_W-1:0]            r_rp, n_rp;
    logic [PTR_W-1:0]            r_cwp, n_cwp;
    logic [PTR_W-1:0]            r_pwp, n_pwp;
    logic [ROOM_W-1:0]           r_room, n_room;
    logic [ROOM_W-1:0]           r_quot, n_quot;
    logic [REM_W-1:0]            r_rem, n_rem;
    logic [CNT_W-1:0]            r_in_cnt, n_in_cnt;
    logic                        r_no_room, n_no_room;
    logic [fts_pkg::BURST_W-1:0] r_left, n_left;
    logic                        r_pre, n_pre;
    logic [7:0]                  r_rd_data;

    // Registered item awaiting its place in the queue.
    logic                        r_s1_valid, n_s1_valid;
    logic                        r_s1_kind, n_s1_kind;
    fts_pkg::t_status            r_s1_status, n_s1_status;
    logic                        r_s1_store, n_s1_store;
    logic [fts_pkg::FF_W-1:0]    r_s1_ff, n_s1_ff;

    logic                        w_accept;
    logic                        w_wr_en;
    logic                        w_rd_en;
    logic                        w_send;
    logic                        w_pre;
    logic [fts_pkg::BURST_W-1:0] w_left;
    logic [fts_pkg::BURST_W-1:0] w_len;
    logic                        w_res;

    assign o_full   = r_s1_valid && i_q_full;
    assign w_accept = i_push && !o_full;
    assign o_q_push = r_s1_valid && !i_q_full;

    // Queue entry: the store byte comes from the registered read port and arrives in the cycle after the read.
    always_comb begin
        o_q_data             = '0;
        o_q_data.kind        = r_s1_kind;
        o_q_data.status      = r_s1_status;
        o_q_data.free_frames = r_s1_ff;
        if (r_s1_kind == fts_pkg::KIND_BIT) begin
            o_q_data.data = r_s1_store ? r_rd_data : fts_pkg::SYNC_BYTE;
        end
    end

    // Item processing: pointer, count and burst updates.
    always_comb begin
        n_rp        = r_rp;
        n_cwp       = r_cwp;
        n_pwp       = r_pwp;
        n_room      = r_room;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_in_cnt    = r_in_cnt;
        n_no_room   = r_no_room;
        n_left      = r_left;
        n_pre       = r_pre;
        n_s1_kind   = r_s1_kind;
        n_s1_status = r_s1_status;
        n_s1_store  = r_s1_store;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_send      = 1'b0;
        w_pre       = r_pre;
        w_left      = r_left;
        w_len       = '0;
        w_res       = 1'b0;

        if (w_accept) begin
            if (i_mode == fts_pkg::MODE_LOAD) begin
                // Store payload bytes, skipping the first byte of the frame.
                if (r_in_cnt != '0 && r_in_cnt <= CNT_W'(FRAME_BYTES)) begin
                    if (CMP_W'(r_in_cnt - 1'b1) >= CMP_W'(r_room)) begin
                        n_no_room = 1'b1;
                    end else if (!r_no_room) begin
                        w_wr_en = 1'b1;
                        n_pwp   = wrap_next(r_pwp);
                    end
                end
                if (r_in_cnt < CNT_W'(FRAME_BYTES + 2)) begin
                    n_in_cnt = r_in_cnt + 1'b1;
                end

                // At frame end, commit or roll back and report.
                if (i_frame_end) begin
                    w_res     = 1'b1;
                    n_s1_kind = fts_pkg::KIND_STATUS;
                    if (n_in_cnt != CNT_W'(FRAME_BYTES + 1)) begin
                        n_s1_status = fts_pkg::ST_LENGTH;
                        n_pwp       = r_cwp;
                    end else if (n_no_room) begin
                        n_s1_status = fts_pkg::ST_NO_ROOM;
                        n_pwp       = r_cwp;
                    end else begin
                        n_s1_status = fts_pkg::ST_OK;
                        n_cwp       = n_pwp;
                        n_room      = r_room - ROOM_W'(FRAME_BYTES);
                        n_quot      = r_quot - 1'b1;
                    end
                    n_in_cnt  = '0;
                    n_no_room = 1'b0;
                end
            end else begin
                // Tick: start a burst when idle, then send one byte.
                if (r_left == '0) begin
                    if (r_room != ROOM_W'(STORE_BYTES)) begin
                        w_len = i_tx_on ? fts_pkg::BURST_W'(FRAME_BYTES) : r_preamble;
                        if (w_len != '0) begin
                            w_send = 1'b1;
                            w_pre  = !i_tx_on;
                            w_left = w_len;
                        end
                    end
                end else begin
                    w_send = 1'b1;
                end

                if (w_send) begin
                    if (!w_pre) begin
                        w_rd_en = 1'b1;
                        n_rp    = wrap_next(r_rp);
                        if (r_room != ROOM_W'(STORE_BYTES)) begin
                            n_room = r_room + 1'b1;
                            if (r_rem == REM_W'(FRAME_BYTES - 1)) begin
                                n_rem  = '0;
                                n_quot = r_quot + 1'b1;
                            end else begin
                                n_rem = r_rem + 1'b1;
                            end
                        end
                    end
                    n_left      = w_left - 1'b1;
                    n_pre       = (w_left == fts_pkg::BURST_W'(1)) ? 1'b0 : w_pre;
                    w_res       = 1'b1;
                    n_s1_kind   = fts_pkg::KIND_BIT;
                    n_s1_status = fts_pkg::ST_OK;
                    n_s1_store  = !w_pre;
                end
            end
        end

        // Free frame count after the item, saturated.
        n_s1_ff = (n_quot > ROOM_W'(fts_pkg::FF_MAX)) ? fts_pkg::FF_MAX
                                                      : n_quot[fts_pkg::FF_W-1:0];

        if (w_res) begin
            n_s1_valid = 1'b1;
        end else if (o_q_push) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    // Control and pointer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble <= fts_pkg::PREAMBLE_RESET;
            r_rp       <= '0;
            r_cwp      <= '0;
            r_pwp      <= '0;
            r_room     <= ROOM_W'(STORE_BYTES);
            r_quot     <= ROOM_W'(Q_RESET);
            r_rem      <= REM_W'(R_RESET);
            r_in_cnt   <= '0;
            r_no_room  <= 1'b0;
            r_left     <= '0;
            r_pre      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_preamble <= i_cfg_wdata;
            end
            r_rp       <= n_rp;
            r_cwp      <= n_cwp;
            r_pwp      <= n_pwp;
            r_room     <= n_room;
            r_quot     <= n_quot;
            r_rem      <= n_rem;
            r_in_cnt   <= n_in_cnt;
            r_no_room  <= n_no_room;
            r_left     <= n_left;
            r_pre      <= n_pre;
            r_s1_valid <= n_s1_valid;
        end
    end

    // Payload of the waiting entry.
    always_ff @(posedge i_clk) begin
        if (w_res) begin
            r_s1_kind   <= n_s1_kind;
            r_s1_status <= n_s1_status;
            r_s1_store  <= n_s1_store;
            r_s1_ff     <= n_s1_ff;
        end
    end

    // Byte store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_pwp] <= i_data_byte;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_rp];
        end
    end

endmodule

// ===== src/fts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_queue
// Short first-in first-out queue of result entries between the front and
// the serializer.
// ----------------------------------------------------------------------------
module fts_queue #(
    parameter int DEPTH = fts_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fts_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output fts_pkg::t_entry o_data,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fts_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointer and occupancy update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/fts_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_back
// Serializer: gives a status entry as one result and a byte entry as eight
// bit results, most significant bit first.
// ----------------------------------------------------------------------------
module fts_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fts_pkg::t_entry           i_head,
    input  logic                      i_head_empty,
    output logic                      o_head_pop,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic                      o_kind,
    output logic [1:0]                o_status,
    output logic                      o_out_bit,
    output logic                      o_byte_last,
    output logic [fts_pkg::FF_W-1:0]  o_free_frames
);

    logic [2:0] r_idx, n_idx;
    logic       w_xfer;
    logic       w_is_bit;

    assign o_empty       = i_head_empty;
    assign w_xfer        = i_pop && !i_head_empty;
    assign w_is_bit      = (i_head.kind == fts_pkg::KIND_BIT);
    assign o_kind        = i_head.kind;
    assign o_status      = w_is_bit ? fts_pkg::ST_OK : i_head.status;
    assign o_out_bit     = w_is_bit && i_head.data[3'd7 - r_idx];
    assign o_byte_last   = w_is_bit && (r_idx == 3'd7);
    assign o_free_frames = i_head.free_frames;

    // The entry leaves the queue with its last result.
    assign o_head_pop = w_xfer && (!w_is_bit || r_idx == 3'd7);

    // Bit index within the current byte.
    always_comb begin
        n_idx = r_idx;
        if (w_xfer && w_is_bit) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

// ===== src/frame_tx_preamble_serializer.sv =====
`timescale 1ns / 1ps
// Timing: a result is offered after its item has passed the staging register
// and the queue. Throughput: one item per cycle; a tick that sends a byte yields eight bit
// results, one per cycle while the receiver pops, so ticks run back to back until
// the four-entry queue and the staging register fill, after which every item waits.
// Reset: synchronous, active low; pointers, counts and queue clear at once,
// the byte store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// frame_tx_preamble_serializer
// Transmit framer: stores fixed-length frames, sends a 0x77 preamble or the
// next frame per tick, and serializes each byte MSB first.
// ----------------------------------------------------------------------------
module frame_tx_preamble_serializer #(
    parameter int FRAME_BYTES = fts_pkg::FRAME_BYTES_DEF,
    parameter int STORE_BYTES = fts_pkg::STORE_BYTES_DEF,
    parameter int QUEUE_DEPTH = fts_pkg::QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [fts_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_mode,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_frame_end,
    input  logic                      i_tx_on,
    output logic                      empty,
    input  logic                      pop,
    output logic                      o_kind,
    output logic [1:0]                o_status,
    output logic                      o_out_bit,
    output logic                      o_byte_last,
    output logic [fts_pkg::FF_W-1:0]  o_free_frames
);

    logic            w_q_push;
    logic            w_q_full;
    logic            w_q_pop;
    logic            w_q_empty;
    fts_pkg::t_entry w_q_in;
    fts_pkg::t_entry w_q_head;

    // Front: item handling and byte store.
    fts_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .STORE_BYTES (STORE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_frame_end (i_frame_end),
        .i_tx_on     (i_tx_on),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_in)
    );

    // Queue between front and serializer.
    fts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_head),
        .o_empty (w_q_empty)
    );

    // Serializer.
    fts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_q_head),
        .i_head_empty  (w_q_empty),
        .o_head_pop    (w_q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_kind        (o_kind),
        .o_status      (o_status),
        .o_out_bit     (o_out_bit),
        .o_byte_last   (o_byte_last),
        .o_free_frames (o_free_frames)
    );

    // The front never pushes into a full queue, so no entry is dropped.
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("entry pushed into full result queue");

    // The eighth-bit marker only appears on bit results.
    a_last_is_bit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_last) |-> o_kind)
        else $error("byte_last on a status result");

    // A status result always carries a defined code.
    a_status_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_kind) |-> (o_status != 2'd3))
        else $error("undefined load status");

    // An entry leaves the queue only on a transfer at the output.
    a_pop_on_transfer : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> (pop && !empty))
        else $error("queue popped without output transfer");

endmodule

// ===== bench/framer_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framer_result_checker
// Watches the item, result and register ports of the transmit framer, keeps
// its own model of the byte store and burst logic, and compares every result
// transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module framer_result_checker #(
    parameter int FRAME_BYTES = fts_pkg::FRAME_BYTES_DEF,
    parameter int STORE_BYTES = fts_pkg::STORE_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [fts_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_push,
    input  logic                      i_full,
    input  logic                      i_mode,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_frame_end,
    input  logic                      i_tx_on,
    input  logic                      i_empty,
    input  logic                      i_pop,
    input  logic                      i_kind,
    input  logic [1:0]                i_status,
    input  logic                      i_out_bit,
    input  logic                      i_byte_last,
    input  logic [fts_pkg::FF_W-1:0]  i_free_frames,
    output int                        o_error_count,
    output int                        o_pending,
    output logic                      o_burst_busy,
    output logic [11:0]               o_stored_bytes
);

    import fts_pkg::*;

    localparam int PTR_W = $clog2(STORE_BYTES);

    // One predicted result transfer.
    typedef struct packed {
        logic            kind;
        logic [1:0]      status;
        logic            out_bit;
        logic            byte_last;
        logic [FF_W-1:0] free_frames;
    } t_tx_result;

    t_tx_result expected_results[$];
    int         error_count;

    // Model state of the framer.
    logic [7:0]         store_mem [STORE_BYTES];
    logic [PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]   commit_ptr;
    logic [PTR_W-1:0]   wr_ptr;
    logic [11:0]        stored_bytes;
    logic [7:0]         frame_count;
    logic               frame_no_room;
    logic [BURST_W-1:0] burst_len;
    logic [BURST_W-1:0] burst_pos;
    logic               sending_preamble;
    logic [CFG_W-1:0]   preamble_len;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (int'(p) == STORE_BYTES - 1) ? '0 : p + 1'b1;
    endfunction

    // Whole frames that still fit, saturated to the field width.
    function automatic logic [FF_W-1:0] frames_free();
        int room;
        int frames;
        room   = (int'(stored_bytes) < STORE_BYTES) ? STORE_BYTES - int'(stored_bytes) : 0;
        frames = room / FRAME_BYTES;
        return (frames > int'(FF_MAX)) ? FF_MAX : FF_W'(frames);
    endfunction

    task automatic clear_state();
        expected_results.delete();
        rd_ptr           = '0;
        commit_ptr       = '0;
        wr_ptr           = '0;
        stored_bytes     = '0;
        frame_count      = '0;
        frame_no_room    = 1'b0;
        burst_len        = '0;
        burst_pos        = '0;
        sending_preamble = 1'b0;
        preamble_len     = PREAMBLE_RESET;
    endtask

    // A load byte: the first byte of a frame is dropped, the payload goes to
    // the pending area, and the frame end commits or rolls back.
    task automatic predict_load(input logic [7:0] data, input logic last);
        int         n;
        t_tx_result r;
        n = int'(frame_count);
        if (n >= 1 && n <= FRAME_BYTES) begin
            if (int'(stored_bytes) + n - 1 >= STORE_BYTES) begin
                frame_no_room = 1'b1;
            end else if (!frame_no_room) begin
                store_mem[wr_ptr] = data;
                wr_ptr            = ptr_next(wr_ptr);
            end
        end
        if (n < FRAME_BYTES + 2) begin
            frame_count = 8'(n + 1);
        end
        if (!last) begin
            return;
        end
        // A wrong length wins over a lack of room.
        if (int'(frame_count) != FRAME_BYTES + 1) begin
            r.status = ST_LENGTH;
            wr_ptr   = commit_ptr;
        end else if (frame_no_room) begin
            r.status = ST_NO_ROOM;
            wr_ptr   = commit_ptr;
        end else begin
            r.status     = ST_OK;
            commit_ptr   = wr_ptr;
            stored_bytes = stored_bytes + 12'(FRAME_BYTES);
        end
        frame_count      = '0;
        frame_no_room    = 1'b0;
        r.kind           = KIND_STATUS;
        r.out_bit        = 1'b0;
        r.byte_last      = 1'b0;
        r.free_frames    = frames_free();
        expected_results.push_back(r);
    endtask

    // A tick: start a preamble or a frame when idle, then send one byte as
    // eight bit results, most significant bit first.
    task automatic predict_tick(input logic tx_on);
        logic [7:0] b;
        t_tx_result r;
        if (burst_len == '0) begin
            if (stored_bytes == '0) begin
                return;
            end
            if (!tx_on) begin
                sending_preamble = 1'b1;
                burst_len        = preamble_len;
            end else begin
                sending_preamble = 1'b0;
                burst_len        = BURST_W'(FRAME_BYTES);
            end
            burst_pos = '0;
            // A zero-length preamble sends nothing and leaves the block idle.
            if (burst_len == '0) begin
                sending_preamble = 1'b0;
                return;
            end
        end
        if (sending_preamble) begin
            b = SYNC_BYTE;
        end else begin
            b      = store_mem[rd_ptr];
            rd_ptr = ptr_next(rd_ptr);
            if (stored_bytes != '0) begin
                stored_bytes = stored_bytes - 1'b1;
            end
        end
        burst_pos = burst_pos + 1'b1;
        if (burst_pos >= burst_len) begin
            burst_len        = '0;
            burst_pos        = '0;
            sending_preamble = 1'b0;
        end
        for (int i = 0; i < 8; i++) begin
            r.kind        = KIND_BIT;
            r.status      = ST_OK;
            r.out_bit     = b[7-i];
            r.byte_last   = (i == 7);
            r.free_frames = frames_free();
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    initial begin
        error_count = 0;
        clear_state();
    end

    // Results are compared before the item of the same edge is predicted, so
    // a stray result can never match an expectation that is not yet due.
    always @(posedge i_clk) begin : watch_proc
        t_tx_result head;
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with none expected, kind %0d",
                             $time, i_kind);
                    error_count++;
                end else begin
                    head = expected_results.pop_front();
                    check_field("kind", 8'(head.kind), 8'(i_kind));
                    check_field("status", 8'(head.status), 8'(i_status));
                    check_field("out_bit", 8'(head.out_bit), 8'(i_out_bit));
                    check_field("byte_last", 8'(head.byte_last), 8'(i_byte_last));
                    check_field("free_frames", 8'(head.free_frames), 8'(i_free_frames));
                end
            end
            if (i_cfg_we) begin
                preamble_len = i_cfg_wdata;
            end
            if (i_push && !i_full) begin
                if (i_mode == MODE_LOAD) begin
                    predict_load(i_data_byte, i_frame_end);
                end else begin
                    predict_tick(i_tx_on);
                end
            end
        end
        o_error_count  <= error_count;
        o_pending      <= expected_results.size();
        o_burst_busy   <= (burst_len != '0);
        o_stored_bytes <= stored_bytes;
    end

endmodule

// ===== bench/frame_tx_preamble_serializer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_tx_preamble_serializer_tb
// Drives load and tick items into the transmit framer with random gaps on
// both handshakes: rejected and accepted frames, a zero-length and a short
// preamble, then the stored frame. All checking is left to the result checker.
// ----------------------------------------------------------------------------
module frame_tx_preamble_serializer_tb;

    import fts_pkg::*;

    localparam int FRAME_LEN    = FRAME_BYTES_DEF;
    localparam int GOOD_LEN     = FRAME_BYTES_DEF + 1;
    localparam int SETTLE       = 8;
    localparam int LIMIT_CYCLES = 4000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_wdata;
    logic              push;
    logic              full;
    logic              i_mode;
    logic [7:0]        i_data_byte;
    logic              i_frame_end;
    logic              i_tx_on;
    logic              empty;
    logic              pop;
    logic              o_kind;
    logic [1:0]        o_status;
    logic              o_out_bit;
    logic              o_byte_last;
    logic [FF_W-1:0]   o_free_frames;

    int                error_count;
    int                pending;
    logic              burst_busy;
    logic [11:0]       stored_bytes;

    int                cycle_count = 0;
    bit                steady;

    frame_tx_preamble_serializer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_mode       (i_mode),
        .i_data_byte  (i_data_byte),
        .i_frame_end  (i_frame_end),
        .i_tx_on      (i_tx_on),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_status     (o_status),
        .o_out_bit    (o_out_bit),
        .o_byte_last  (o_byte_last),
        .o_free_frames(o_free_frames)
    );

    framer_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (push),
        .i_full        (full),
        .i_mode        (i_mode),
        .i_data_byte   (i_data_byte),
        .i_frame_end   (i_frame_end),
        .i_tx_on       (i_tx_on),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_kind        (o_kind),
        .i_status      (o_status),
        .i_out_bit     (o_out_bit),
        .i_byte_last   (o_byte_last),
        .i_free_frames (o_free_frames),
        .o_error_count (error_count),
        .o_pending     (pending),
        .o_burst_busy  (burst_busy),
        .o_stored_bytes(stored_bytes)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long; none in steady phases.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 24);
    endfunction

    // One item transfer; with hold set the sender always rests for a while
    // afterwards, so the checker's view is up to date on return.
    task automatic send_item(input logic mode, input logic [7:0] data,
                             input logic last, input logic tx_on, input bit hold);
        int gap;
        push        <= 1'b1;
        i_mode      <= mode;
        i_data_byte <= data;
        i_frame_end <= last;
        i_tx_on     <= tx_on;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        gap = pick_gap();
        if (hold && gap == 0) begin
            gap = 1;
        end
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic go_idle();
        push <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold the sender until every predicted result has been transferred.
    task automatic wait_drain();
        go_idle();
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_preamble(input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Tick until the current burst is over, and with whole_store set until
    // the byte store is empty as well.
    task automatic tick_out(input logic tx_on, input bit whole_store);
        go_idle();
        while (burst_busy || (whole_store && stored_bytes != '0)) begin
            send_item(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      tx_on, 1'b1);
        end
    endtask

    task automatic tick(input logic tx_on);
        send_item(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  tx_on, 1'b0);
    endtask

    // One incoming frame of len bytes, optionally with ticks mixed in.
    task automatic load_frame(input int len, input bit mix);
        logic [7:0] d;
        for (int i = 0; i < len; i++) begin
            if (mix && $urandom_range(0, 11) == 0) begin
                tick($urandom_range(0, 3) != 0);
            end
            if (i == 1) begin
                d = 8'h00;
            end else if (i == 2) begin
                d = 8'hFF;
            end else begin
                d = 8'($urandom_range(0, 255));
            end
            send_item(MODE_LOAD, d, (i == len - 1), 1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    // Receiver: runs of pops broken by random stalls.
    initial begin : pop_driver
        int gap;
        pop = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Main stimulus sequence.
    initial begin
        steady      = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        push        = 1'b0;
        i_mode      = MODE_LOAD;
        i_data_byte = '0;
        i_frame_end = 1'b0;
        i_tx_on     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ticks with an empty store send nothing.
        tick(1'b0);
        tick(1'b1);

        // Short frames and an overlong one, whose byte count saturates, are
        // rejected; then a frame of the right length, with ticks mixed in,
        // is taken.
        load_frame(1, 1'b0);
        load_frame(3, 1'b0);
        load_frame(FRAME_LEN + 4, 1'b0);
        load_frame(GOOD_LEN, 1'b1);
        wait_drain();

        // A zero-length preamble sends nothing and the block stays idle.
        write_preamble('0);
        tick(1'b0);
        tick(1'b0);
        wait_drain();

        // A short preamble, then the stored frame: half of it back to back,
        // the rest with random gaps.
        write_preamble(CFG_W'($urandom_range(1, 4)));
        tick(1'b0);
        tick_out(1'b0, 1'b0);
        steady = 1'b1;
        for (int i = 0; i < FRAME_LEN / 2; i++) begin
            tick(($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1);
        end
        steady = 1'b0;
        tick_out(1'b1, 1'b1);
        wait_drain();

        if (error_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
